// ===== hdl/yasf_pkg.sv =====
// ----------------------------------------------------------------------------
// yasf_pkg
// Shared types and constants for the yaw angle source fusion block.
// ----------------------------------------------------------------------------
package yasf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_YAW_STEP_GAIN       = 3'd0;
    localparam logic [2:0] CFG_RATE_GAIN           = 3'd1;
    localparam logic [2:0] CFG_CHASSIS_RATE_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_CHASSIS_SPEED_LIMIT = 3'd3;
    localparam logic [2:0] CFG_SETTLE_TICKS        = 3'd4;
    localparam logic [2:0] CFG_FILTER_WEIGHT       = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_YAW_STEP_GAIN       = 16'd364;
    localparam logic [15:0] RST_RATE_GAIN           = 16'd19995;
    localparam logic [14:0] RST_CHASSIS_RATE_LIMIT  = 15'd10;
    localparam logic [14:0] RST_CHASSIS_SPEED_LIMIT = 15'd100;
    localparam logic [15:0] RST_SETTLE_TICKS        = 16'd500;
    localparam logic [16:0] RST_FILTER_WEIGHT       = 17'd3277;

    // Stillness counter ceiling and Q16 unity.
    localparam logic [15:0] STILL_MAX = 16'hFFFF;
    localparam logic [16:0] Q16_ONE   = 17'h10000;

    // Settings used by the yaw path.
    typedef struct packed {
        logic [15:0] yaw_step_gain;
        logic [14:0] chassis_rate_limit;
        logic [14:0] chassis_speed_limit;
        logic [15:0] settle_ticks;
    } t_yaw_cfg;

    // Yaw path result for one tick.
    typedef struct packed {
        logic [31:0] fused_angle;
        logic        enc_src;
        logic [31:0] gyro_yaw_integral;
    } t_yaw_res;

endpackage

// ===== hdl/yaw_angle_source_fusion.sv =====
// ----------------------------------------------------------------------------
// yaw_angle_source_fusion
// Fuses gyro-integrated and encoder yaw, and provides scaled rates and a
// filtered pitch angle, one result per sensor tick.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Content
// s_axis    in         s_axis_tvalid/s_axis_tready  one sensor tick
// m_axis    out        m_axis_tvalid/m_axis_tready  fused yaw, rates, pitch
// cfg       in         i_cfg_valid/o_cfg_ready      register index and value
//
// Every accepted tick produces exactly one result transfer; it passes
// through the input register and then the output register. The whole
// update of integrator, stillness counter, offsets and pitch filter is a
// single combinational pass from the input register to the output register,
// so one tick per cycle is sustained while the output is not stalled.
// The configuration port is always ready. Reset is synchronous and active
// low; it restores the register defaults and clears the filter state. A
// stalled output holds its data while the input register can still take one
// more tick.
//
module yaw_angle_source_fusion import yasf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,

    // Input tick. tdata from the lowest bit: gyro_yaw_raw[15:0],
    // gyro_pitch_raw[31:16], imu_pitch_angle[47:32],
    // encoder_yaw_angle[79:48], chassis_yaw_rate[95:80],
    // chassis_yaw_speed[111:96].
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,

    // Result. tdata from the lowest bit: fused_angle[31:0],
    // gyro_yaw_integral[63:32], yaw_rate[95:64], pitch_rate[127:96],
    // pitch_filtered[143:128]. tuser: enc_src[0].
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser,

    // Configuration writes.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [16:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_yaw_step_gain;
    logic [15:0] r_rate_gain;
    logic [14:0] r_chassis_rate_limit;
    logic [14:0] r_chassis_speed_limit;
    logic [15:0] r_settle_ticks;
    logic [16:0] r_filter_weight;

    assign o_cfg_ready = 1'b1;

    // Writes to indexes outside the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_step_gain       <= RST_YAW_STEP_GAIN;
            r_rate_gain           <= RST_RATE_GAIN;
            r_chassis_rate_limit  <= RST_CHASSIS_RATE_LIMIT;
            r_chassis_speed_limit <= RST_CHASSIS_SPEED_LIMIT;
            r_settle_ticks        <= RST_SETTLE_TICKS;
            r_filter_weight       <= RST_FILTER_WEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_YAW_STEP_GAIN:       r_yaw_step_gain       <= i_cfg_data[15:0];
                CFG_RATE_GAIN:           r_rate_gain           <= i_cfg_data[15:0];
                CFG_CHASSIS_RATE_LIMIT:  r_chassis_rate_limit  <= i_cfg_data[14:0];
                CFG_CHASSIS_SPEED_LIMIT: r_chassis_speed_limit <= i_cfg_data[14:0];
                CFG_SETTLE_TICKS:        r_settle_ticks        <= i_cfg_data[15:0];
                CFG_FILTER_WEIGHT:       r_filter_weight       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    // The input register moves into the output register whenever the
    // output register is empty or is being drained in the same cycle.
    // That move is also the moment all filter and yaw state advances.
    logic         r_in_valid;
    logic [111:0] r_in_data;
    logic         advance;

    assign advance       = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
    end

    logic signed [15:0] gyro_yaw_raw;
    logic signed [15:0] gyro_pitch_raw;
    logic signed [15:0] imu_pitch_angle;
    logic [31:0]        encoder_yaw_angle;
    logic signed [15:0] chassis_yaw_rate;
    logic signed [15:0] chassis_yaw_speed;

    assign gyro_yaw_raw      = r_in_data[15:0];
    assign gyro_pitch_raw    = r_in_data[31:16];
    assign imu_pitch_angle   = r_in_data[47:32];
    assign encoder_yaw_angle = r_in_data[79:48];
    assign chassis_yaw_rate  = r_in_data[95:80];
    assign chassis_yaw_speed = r_in_data[111:96];

    // ------------------------------------------------------------------
    // Yaw integration and source selection
    // ------------------------------------------------------------------
    t_yaw_cfg yaw_cfg;
    t_yaw_res yaw_res;

    assign yaw_cfg.yaw_step_gain       = r_yaw_step_gain;
    assign yaw_cfg.chassis_rate_limit  = r_chassis_rate_limit;
    assign yaw_cfg.chassis_speed_limit = r_chassis_speed_limit;
    assign yaw_cfg.settle_ticks        = r_settle_ticks;

    yasf_yaw u_yaw (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (advance),
        .i_cfg               (yaw_cfg),
        .i_gyro_yaw_raw      (gyro_yaw_raw),
        .i_encoder_yaw_angle (encoder_yaw_angle),
        .i_chassis_yaw_rate  (chassis_yaw_rate),
        .i_chassis_yaw_speed (chassis_yaw_speed),
        .o_res               (yaw_res)
    );

    // ------------------------------------------------------------------
    // Pitch complementary filter
    // ------------------------------------------------------------------
    logic signed [15:0] pitch_filtered;

    yasf_pitch u_pitch (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (advance),
        .i_filter_weight   (r_filter_weight),
        .i_imu_pitch_angle (imu_pitch_angle),
        .o_pitch_filtered  (pitch_filtered)
    );

    // ------------------------------------------------------------------
    // Scaled rates. A 16-bit count times a 16-bit gain always fits in
    // 32 signed bits, so the low word is the exact result.
    // ------------------------------------------------------------------
    logic signed [16:0] rate_gain_s;
    logic signed [32:0] yaw_rate_prod;
    logic signed [32:0] pitch_rate_prod;
    logic [31:0]        yaw_rate;
    logic [31:0]        pitch_rate;

    assign rate_gain_s     = {1'b0, r_rate_gain};
    assign yaw_rate_prod   = 33'(gyro_yaw_raw) * 33'(rate_gain_s);
    assign pitch_rate_prod = 33'(gyro_pitch_raw) * 33'(rate_gain_s);
    assign yaw_rate        = yaw_rate_prod[31:0];
    assign pitch_rate      = 32'd0 - pitch_rate_prod[31:0];

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic         r_out_valid;
    logic [143:0] r_out_data;
    logic         r_out_enc_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data    <= {pitch_filtered, pitch_rate, yaw_rate,
                              yaw_res.gyro_yaw_integral, yaw_res.fused_angle};
            r_out_enc_src <= yaw_res.enc_src;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_enc_src;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty output register must never hold back the input side.
    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready
    ) else $error("input stalled while output register is empty");

    // A tick held in the input register keeps its data until it moves on.
    a_in_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_data)
    ) else $error("pending tick lost or changed in input register");

    // Every move into the output register presents a result next cycle.
    a_advance_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance |=> m_axis_tvalid
    ) else $error("advanced tick did not produce a result");

    // When both registers are full and the output is stalled, no tick is taken.
    a_full_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready
    ) else $error("tick accepted while pipeline is full and stalled");

endmodule

// ===== hdl/yasf_yaw.sv =====
// ----------------------------------------------------------------------------
// yasf_yaw
// Gyro yaw integrator, stillness counter and yaw source selection.
// ----------------------------------------------------------------------------
module yasf_yaw import yasf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_yaw_cfg          i_cfg,
    input  logic signed [15:0] i_gyro_yaw_raw,
    input  logic [31:0]       i_encoder_yaw_angle,
    input  logic signed [15:0] i_chassis_yaw_rate,
    input  logic signed [15:0] i_chassis_yaw_speed,
    output t_yaw_res          o_res
);

    logic [31:0] r_integral, n_integral;
    logic [15:0] r_still, n_still;
    logic        r_src_enc;
    logic [31:0] r_enc_off, n_enc_off;
    logic [31:0] r_gyro_off, n_gyro_off;
    logic [31:0] r_fused, n_fused;

    logic signed [16:0] gain_s;
    logic signed [32:0] step_prod;
    logic [16:0]        rate_abs, speed_abs;
    logic               still;
    logic               to_enc;
    logic               sw_to_enc, sw_to_gyro;

    assign gain_s     = {1'b0, i_cfg.yaw_step_gain};
    assign step_prod  = 33'(i_gyro_yaw_raw) * 33'(gain_s);
    assign n_integral = r_integral + step_prod[31:0];

    assign rate_abs  = i_chassis_yaw_rate[15]
                     ? 17'd0 - {i_chassis_yaw_rate[15], i_chassis_yaw_rate}
                     : {1'b0, i_chassis_yaw_rate};
    assign speed_abs = i_chassis_yaw_speed[15]
                     ? 17'd0 - {i_chassis_yaw_speed[15], i_chassis_yaw_speed}
                     : {1'b0, i_chassis_yaw_speed};
    assign still = (rate_abs < {2'b00, i_cfg.chassis_rate_limit})
                && (speed_abs < {2'b00, i_cfg.chassis_speed_limit});

    always_comb begin
        if (!still) begin
            n_still = '0;
        end else if (r_still == STILL_MAX) begin
            n_still = r_still;
        end else begin
            n_still = r_still + 16'd1;
        end
    end

    assign to_enc     = n_still > i_cfg.settle_ticks;
    assign sw_to_enc  = to_enc && !r_src_enc;
    assign sw_to_gyro = !to_enc && r_src_enc;

    // On a switch the new offset is chosen so that the fused yaw keeps its
    // previous value, so the fused value simply holds on that tick.
    assign n_enc_off  = sw_to_enc  ? i_encoder_yaw_angle - r_fused : r_enc_off;
    assign n_gyro_off = sw_to_gyro ? n_integral - r_fused          : r_gyro_off;

    always_comb begin
        if (sw_to_enc || sw_to_gyro) begin
            n_fused = r_fused;
        end else if (to_enc) begin
            n_fused = i_encoder_yaw_angle - r_enc_off;
        end else begin
            n_fused = n_integral - r_gyro_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_still    <= '0;
            r_src_enc  <= 1'b1;
            r_enc_off  <= '0;
            r_gyro_off <= '0;
            r_fused    <= '0;
        end else if (i_step) begin
            r_integral <= n_integral;
            r_still    <= n_still;
            r_src_enc  <= to_enc;
            r_enc_off  <= n_enc_off;
            r_gyro_off <= n_gyro_off;
            r_fused    <= n_fused;
        end
    end

    assign o_res.fused_angle       = n_fused;
    assign o_res.enc_src           = to_enc;
    assign o_res.gyro_yaw_integral = n_integral;

endmodule

// ===== hdl/yasf_pitch.sv =====
// ----------------------------------------------------------------------------
// yasf_pitch
// First-order complementary filter on the negated IMU pitch angle.
// ----------------------------------------------------------------------------
module yasf_pitch import yasf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [16:0]        i_filter_weight,
    input  logic signed [15:0] i_imu_pitch_angle,
    output logic signed [15:0] o_pitch_filtered
);

    logic signed [15:0] r_state, n_state;

    logic [16:0]        w;
    logic signed [17:0] w_s, wc_s;
    logic signed [16:0] neg_p;
    logic signed [34:0] prod_new, prod_old;
    logic signed [36:0] acc;
    logic signed [20:0] scaled;

    // Weights above unity act as unity.
    assign w     = (i_filter_weight > Q16_ONE) ? Q16_ONE : i_filter_weight;
    assign w_s   = {1'b0, w};
    assign wc_s  = {1'b0, Q16_ONE} - w_s;
    assign neg_p = 17'sd0 - {i_imu_pitch_angle[15], i_imu_pitch_angle};

    assign prod_new = 35'(w_s) * 35'(neg_p);
    assign prod_old = 35'(wc_s) * 35'(r_state);

    // Round half up, then drop the sixteen fraction bits.
    assign acc    = 37'(prod_new) + 37'(prod_old) + 37'sd32768;
    assign scaled = acc[36:16];

    always_comb begin
        if (scaled > 21'sd32767) begin
            n_state = 16'sh7FFF;
        end else if (scaled < -21'sd32768) begin
            n_state = 16'sh8000;
        end else begin
            n_state = scaled[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_pitch_filtered = n_state;

endmodule
